/* rtl/pds_pkg.sv */
// package for the positional deque store: sizes, action and status codes,
// and the packed item types of both channels. no dependencies
package pds_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int OCNT_W   = 6;
  localparam int WORD_W   = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] ACT_ADD_FRONT    = 3'd0;
  localparam logic [2:0] ACT_ADD_BACK     = 3'd1;
  localparam logic [2:0] ACT_REMOVE_FRONT = 3'd2;
  localparam logic [2:0] ACT_REMOVE_BACK  = 3'd3;
  localparam logic [2:0] ACT_CLEAR        = 3'd4;
  localparam logic [2:0] ACT_INSERT_AFTER = 3'd5;
  localparam logic [2:0] ACT_REMOVE_AT    = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]               action;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } pds_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [OCNT_W-1:0]        count;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } pds_out_t;

endpackage

/* rtl/positional_deque_store.sv */
// positional deque store top level: word memory, shift sequencer, output register
// depends on pds_pkg
//
// Bounded ordered store of CAPACITY signed words with add/remove at either end,
// clear, insert after position n and remove at position n (positions from 1).
// Words live in a single-port-write, single-port-read memory with registered read
// data, so an insert or remove moves the words behind the position one at a time
// through a read state and a write state, and an insert then writes the new word
// in a put state. Clear, rejected items and a remove at the back move no words;
// an add at the front of a nearly full store moves the most words.
// Input stall is high from acceptance until the result is loaded into the output
// register; a finished result waiting to be taken does not hold off the next item.
module positional_deque_store import pds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  pds_in_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output pds_out_t out_data_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SH_RD    = 3'd1;
  localparam logic [2:0] S_SH_WR    = 3'd2;
  localparam logic [2:0] S_PUT      = 3'd3;
  localparam logic [2:0] S_RD_FRONT = 3'd4;
  localparam logic [2:0] S_RD_BACK  = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [WORD_W-1:0] mem [CAPACITY];

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  at_q, at_d;
  logic              up_q, up_d;
  logic [WORD_W-1:0] value_q, value_d;
  logic [1:0]        status_q, status_d;
  logic [WORD_W-1:0] front_q, front_d;
  logic [WORD_W-1:0] rdata_q;
  pds_out_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;

  // shared index unit
  logic [IDX_W-1:0]  idx_inc, idx_dec;
  assign idx_inc = idx_q + IDX_W'(1);
  assign idx_dec = idx_q - IDX_W'(1);

  // decode of an arriving item
  logic             full, empty, pos_ok;
  logic [CMP_W-1:0] pos_c, cnt_c;
  assign full  = (cnt_q == CNT_W'(CAPACITY));
  assign empty = (cnt_q == '0);
  assign pos_c = CMP_W'(in_data_i.position);
  assign cnt_c = CMP_W'(cnt_q);
  assign pos_ok = (pos_c != '0) && (pos_c <= cnt_c);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic             do_ins, do_rem;
    logic [IDX_W-1:0] at;
    logic [CNT_W-1:0] at_n;
    do_ins = 1'b0;
    do_rem = 1'b0;
    at     = '0;
    at_n   = '0;

    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    at_d        = at_q;
    up_d        = up_q;
    value_d     = value_q;
    status_d    = status_q;
    front_d     = front_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata_q;
    raddr       = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          value_d  = in_data_i.value;
          status_d = ST_OK;
          case (in_data_i.action)
            ACT_ADD_FRONT: begin
              if (full) status_d = ST_FULL;
              else begin
                do_ins = 1'b1;
                at     = '0;
              end
            end
            ACT_ADD_BACK: begin
              if (full) status_d = ST_FULL;
              else begin
                do_ins = 1'b1;
                at     = IDX_W'(cnt_q);
              end
            end
            ACT_REMOVE_FRONT: begin
              if (empty) status_d = ST_EMPTY;
              else begin
                do_rem = 1'b1;
                at     = '0;
              end
            end
            ACT_REMOVE_BACK: begin
              if (empty) status_d = ST_EMPTY;
              else begin
                do_rem = 1'b1;
                at     = IDX_W'(cnt_q - CNT_W'(1));
              end
            end
            ACT_CLEAR: cnt_d = '0;
            ACT_INSERT_AFTER: begin
              // position is checked before fullness
              if (!pos_ok) status_d = ST_BADPOS;
              else if (full) status_d = ST_FULL;
              else begin
                do_ins = 1'b1;
                at     = IDX_W'(in_data_i.position);
              end
            end
            ACT_REMOVE_AT: begin
              if (empty) status_d = ST_EMPTY;
              else if (!pos_ok) status_d = ST_BADPOS;
              else begin
                do_rem = 1'b1;
                at     = IDX_W'(in_data_i.position - POS_W'(1));
              end
            end
            default: status_d = ST_BADPOS;
          endcase

          at_d    = at;
          at_n    = CNT_W'(at);
          up_d    = do_ins;
          state_d = S_RD_FRONT;
          if (do_ins) begin
            if (at_n < cnt_q) begin
              idx_d   = IDX_W'(cnt_q - CNT_W'(1));
              state_d = S_SH_RD;
            end else begin
              state_d = S_PUT;
            end
          end else if (do_rem) begin
            if (at_n + CNT_W'(1) < cnt_q) begin
              idx_d   = at + IDX_W'(1);
              state_d = S_SH_RD;
            end else begin
              cnt_d = cnt_q - CNT_W'(1);
            end
          end
        end
      end
      S_SH_RD: begin
        raddr   = idx_q;
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        // move the word just read one slot up or down
        we    = 1'b1;
        wdata = rdata_q;
        if (up_q) begin
          waddr = idx_inc;
          if (idx_q == at_q) begin
            state_d = S_PUT;
          end else begin
            idx_d   = idx_dec;
            state_d = S_SH_RD;
          end
        end else begin
          waddr = idx_dec;
          if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = S_RD_FRONT;
          end else begin
            idx_d   = idx_inc;
            state_d = S_SH_RD;
          end
        end
      end
      S_PUT: begin
        we      = 1'b1;
        waddr   = at_q;
        wdata   = value_q;
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = S_RD_FRONT;
      end
      S_RD_FRONT: begin
        raddr   = '0;
        state_d = S_RD_BACK;
      end
      S_RD_BACK: begin
        raddr   = IDX_W'(cnt_q - CNT_W'(1));
        front_d = rdata_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        // keep the back word in the read register while the output is held
        raddr = IDX_W'(cnt_q - CNT_W'(1));
        if (!out_valid_q || !out_stall_i) begin
          out_d.status      = status_q;
          out_d.count       = OCNT_W'(cnt_q);
          out_d.front_value = (cnt_q == '0) ? '0 : front_q;
          out_d.back_value  = (cnt_q == '0) ? '0 : rdata_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    at_q     <= at_d;
    up_q     <= up_d;
    value_q  <= value_d;
    status_q <= status_d;
    front_q  <= front_d;
    out_q    <= out_d;
  end

endmodule
